@@ design/crc_pkg.sv @@
// Shared constants for the coverage run caller: item codes, register indexes, reset values.
package crc_pkg;

	// Item kinds carried in the func field
	localparam logic FUNC_SEGMENT = 1'b0;
	localparam logic FUNC_FLUSH   = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_COUNT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SPAN  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_GAP   = 2'd2;

	// Register values after reset
	localparam int MIN_COUNT_RST = 10;
	localparam int MIN_SPAN_RST  = 14;
	localparam int MAX_GAP_RST   = 44;

endpackage

@@ design/crc_seg_if.sv @@
// Segment input channel: valid/ready handshake with one coverage segment or flush.
interface crc_seg_if #(
	parameter int POS_BITS    = 31,
	parameter int SEQ_ID_BITS = 16,
	parameter int COUNT_BITS  = 24
);
	logic                   valid;
	logic                   ready;
	logic                   func;
	logic [SEQ_ID_BITS-1:0] seq_id;
	logic [POS_BITS-1:0]    seg_start;
	logic [POS_BITS-1:0]    seg_end;
	logic [COUNT_BITS-1:0]  read_count;

	modport source (output valid, func, seq_id, seg_start, seg_end, read_count, input ready);
	modport sink   (input valid, func, seq_id, seg_start, seg_end, read_count, output ready);
endinterface

@@ design/crc_run_if.sv @@
// Run output channel: valid/ready handshake with one emitted run.
interface crc_run_if #(
	parameter int POS_BITS    = 31,
	parameter int SEQ_ID_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [SEQ_ID_BITS-1:0] run_seq_id;
	logic [POS_BITS-1:0]    run_first;
	logic [POS_BITS-1:0]    run_last;

	modport source (output valid, run_seq_id, run_first, run_last, input ready);
	modport sink   (input valid, run_seq_id, run_first, run_last, output ready);
endinterface

@@ design/crc_cfg_if.sv @@
// Configuration write channel: valid/ready handshake with register index and data.
interface crc_cfg_if #(
	parameter int DATA_BITS = 31
);
	logic                               valid;
	logic                               ready;
	logic [crc_pkg::CFG_IDX_BITS-1:0]   index;
	logic [DATA_BITS-1:0]               data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ design/coverage_run_caller.sv @@
// A run is loaded into the output register when the item that closes it advances out of the input register.
// Throughput: one item per cycle unless the run channel stalls; an item lands in the input register,
// and when it advances, the run state update and the output register load happen together.
// The input side stalls only while the input register holds an item and a waiting run is not taken.
// Reset (arst_n low, asynchronous) clears the run state and loads min_count 10, min_span 14,
// max_gap 44; no item is in flight afterwards.
module coverage_run_caller #(
	parameter int POS_BITS    = 31,
	parameter int SEQ_ID_BITS = 16,
	parameter int COUNT_BITS  = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	crc_seg_if.sink    seg,
	crc_run_if.source  run,
	crc_cfg_if.sink    cfg
);

	localparam int DIFF_BITS = POS_BITS + 1;

	// Configuration registers
	logic [COUNT_BITS-1:0] min_count_q;
	logic [POS_BITS-1:0]   min_span_q;
	logic [POS_BITS-1:0]   max_gap_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_count_q <= COUNT_BITS'(crc_pkg::MIN_COUNT_RST);
			min_span_q  <= POS_BITS'(crc_pkg::MIN_SPAN_RST);
			max_gap_q   <= POS_BITS'(crc_pkg::MAX_GAP_RST);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				crc_pkg::CFG_MIN_COUNT: min_count_q <= cfg.data[COUNT_BITS-1:0];
				crc_pkg::CFG_MIN_SPAN:  min_span_q  <= cfg.data[POS_BITS-1:0];
				crc_pkg::CFG_MAX_GAP:   max_gap_q   <= cfg.data[POS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Input register stage
	logic                   valid_s1;
	logic                   func_s1;
	logic [SEQ_ID_BITS-1:0] seq_s1;
	logic [POS_BITS-1:0]    start_s1;
	logic [POS_BITS-1:0]    end_s1;
	logic [COUNT_BITS-1:0]  count_s1;
	logic                   advance;
	logic                   seg_xfer;

	assign advance  = valid_s1 && (!run.valid || run.ready);
	assign seg.ready = !valid_s1 || advance;
	assign seg_xfer = seg.valid && seg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (seg_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seg_xfer) begin
			func_s1  <= seg.func;
			seq_s1   <= seg.seq_id;
			start_s1 <= seg.seg_start;
			end_s1   <= seg.seg_end;
			count_s1 <= seg.read_count;
		end
	end

	// Run state
	logic [SEQ_ID_BITS-1:0] last_seq_q;
	logic                   seen_any_q;
	logic                   in_run_q;
	logic [POS_BITS-1:0]    open_start_q;
	logic [POS_BITS-1:0]    open_end_q;

	// Signed span of the open run and gap from its end to the new segment
	logic signed [DIFF_BITS-1:0] span_diff;
	logic signed [DIFF_BITS-1:0] gap_diff;
	logic span_ok, gap_ok, qual, seq_change, run_cont, emit;

	assign span_diff  = $signed({1'b0, open_end_q}) - $signed({1'b0, open_start_q});
	assign gap_diff   = $signed({1'b0, start_s1}) - $signed({1'b0, open_end_q});
	assign span_ok    = in_run_q && (span_diff >= $signed({1'b0, min_span_q}));
	assign gap_ok     = gap_diff >= $signed({1'b0, max_gap_q});
	assign qual       = count_s1 >= min_count_q;
	assign seq_change = seen_any_q && (seq_s1 != last_seq_q);
	// open run survives the sequence check
	assign run_cont   = in_run_q && !seq_change;

	// The emitted run is always the open one, so only the condition differs by case
	always_comb begin
		if (func_s1 == crc_pkg::FUNC_FLUSH) begin
			emit = span_ok;
		end else begin
			emit = span_ok && (seq_change || (qual && gap_ok));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q   <= '0;
			seen_any_q   <= 1'b0;
			in_run_q     <= 1'b0;
			open_start_q <= '0;
			open_end_q   <= '0;
		end else if (advance) begin
			if (func_s1 == crc_pkg::FUNC_FLUSH) begin
				in_run_q   <= 1'b0;
				seen_any_q <= 1'b0;
			end else begin
				last_seq_q <= seq_s1;
				seen_any_q <= 1'b1;
				if (qual) begin
					in_run_q   <= 1'b1;
					open_end_q <= end_s1;
					if (!run_cont || gap_ok) begin
						open_start_q <= start_s1;
					end
				end else if (seq_change) begin
					in_run_q <= 1'b0;
				end
			end
		end
	end

	// Output register
	logic                   out_valid_q;
	logic [SEQ_ID_BITS-1:0] out_seq_q;
	logic [POS_BITS-1:0]    out_first_q;
	logic [POS_BITS-1:0]    out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (run.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_seq_q   <= last_seq_q;
			out_first_q <= open_start_q;
			out_last_q  <= open_end_q;
		end
	end

	assign run.valid      = out_valid_q;
	assign run.run_seq_id = out_seq_q;
	assign run.run_first  = out_first_q;
	assign run.run_last   = out_last_q;

	// An open run always belongs to a stream that has seen a segment
	a_run_needs_seen: assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q |-> seen_any_q)
		else $error("open run without any segment seen");

	// A processed flush closes the stream
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && func_s1 == crc_pkg::FUNC_FLUSH) |=> (!in_run_q && !seen_any_q))
		else $error("flush left run state open");

	// A held input item keeps its contents
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(func_s1) && $stable(seq_s1)
			&& $stable(start_s1) && $stable(end_s1) && $stable(count_s1)))
		else $error("stalled input register changed");

	// Input stalls only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!seg.ready |-> (run.valid && !run.ready))
		else $error("input stalled without output back-pressure");

endmodule
